@@ rtl/core/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, request codes and control types for the deque core.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int Depth  = 1024;
  localparam int AddrW  = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);
  localparam int DataW  = 32;
  localparam int CapW   = 11;
  localparam int ReqW   = 3;

  localparam logic [CapW-1:0] CapReset = CapW'(1024);

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REPORT     = 3'd4
  } req_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;   // apply the request: pointers, count, store write
    logic read;   // read both ends of the ring
  } ctrl_cmd_t;

  function automatic logic [AddrW-1:0] ring_next(input logic [AddrW-1:0] i);
    return (i == AddrW'(Depth - 1)) ? '0 : i + AddrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] ring_prev(input logic [AddrW-1:0] i);
    return (i == '0) ? AddrW'(Depth - 1) : i - AddrW'(1);
  endfunction

endpackage

@@ rtl/core/bounded_double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core
// Circular deque of 32-bit values with a programmable capacity.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer when            Signals
// request   in         start_i && !busy_o       req_type_i, push_value_i
// result    out        done_o (one cycle)       accepted_o, front_value_o,
//                                               rear_value_o, is_empty_o, is_full_o
// config    in         cfg_valid_i && cfg_ready_o  cfg_data_i (capacity)
//
// On a request transfer the pointers are updated and the store written; the
// READ state then reads both ring ends from the store's registered read
// ports, and the result strobe follows in the RESP state. The next request
// may be accepted in the result cycle; busy_o holds requests off during READ.
// Reset clears pointers and count and sets capacity to 1024; the store is not
// cleared. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [bdq_pkg::ReqW-1:0]         req_type_i,
  input  logic signed [bdq_pkg::DataW-1:0] push_value_i,
  output logic                             done_o,
  output logic                             accepted_o,
  output logic signed [bdq_pkg::DataW-1:0] front_value_o,
  output logic signed [bdq_pkg::DataW-1:0] rear_value_o,
  output logic                             is_empty_o,
  output logic                             is_full_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bdq_pkg::CapW-1:0]         cfg_data_i
);

  bdq_pkg::ctrl_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  bdq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .push_value_i  (push_value_i),
    .accepted_o    (accepted_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result strobe missing two cycles after request transfer");

  a_read_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (done_o && !busy_o))
    else $error("store read not followed by result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> (!busy_o && !done_o))
    else $error("config accepted while a request is in flight");
`endif

endmodule

@@ rtl/core/bdq_ram.sv @@
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

@@ rtl/core/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request sequencer: accept and apply, read both ends, present result.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output logic               cfg_ready_o,
  output bdq_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // a new request may enter while the previous result is on the ports
  assign busy_o      = (state_q == ST_READ);
  assign accept      = start_i && !busy_o;
  assign done_o      = (state_q == ST_RESP);
  assign cfg_ready_o = (state_q == ST_IDLE);

  assign cmd_o.exec = accept;
  assign cmd_o.read = (state_q == ST_READ);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = accept ? ST_READ : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/bdq_dp.sv @@
// ----------------------------------------------------------------------------
// bdq_dp
// Ring datapath: head/tail pointers, entry count, capacity, entry store.
// ----------------------------------------------------------------------------
module bdq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdq_pkg::ctrl_cmd_t                  cmd_i,
  input  logic                                cfg_we_i,
  input  logic [bdq_pkg::CapW-1:0]            cfg_data_i,
  input  logic [bdq_pkg::ReqW-1:0]            req_type_i,
  input  logic signed [bdq_pkg::DataW-1:0]    push_value_i,
  output logic                                accepted_o,
  output logic signed [bdq_pkg::DataW-1:0]    front_value_o,
  output logic signed [bdq_pkg::DataW-1:0]    rear_value_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);

  logic [bdq_pkg::AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [bdq_pkg::CntW-1:0]  count_q, count_d;
  logic [bdq_pkg::CapW-1:0]  cap_q;
  logic                      ok_q, ok_d;
  logic                      full, empty;
  logic                      we;
  logic [bdq_pkg::AddrW-1:0] waddr;
  logic [bdq_pkg::DataW-1:0] rdata_front, rdata_rear;

  // count >= min(capacity, Depth)
  assign full  = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= 32'(bdq_pkg::Depth));
  assign empty = (count_q == '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    ok_d = 1'b0;
    we = 1'b0;
    waddr = tail_q;
    case (req_type_i)
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (!full) begin
          head_d  = bdq_pkg::ring_prev(head_q);
          waddr   = head_d;
          we      = 1'b1;
          count_d = count_q + bdq_pkg::CntW'(1);
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::REQ_PUSH_BACK: begin
        if (!full) begin
          waddr   = tail_q;
          we      = 1'b1;
          tail_d  = bdq_pkg::ring_next(tail_q);
          count_d = count_q + bdq_pkg::CntW'(1);
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        if (!empty) begin
          head_d  = bdq_pkg::ring_next(head_q);
          count_d = count_q - bdq_pkg::CntW'(1);
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::REQ_POP_BACK: begin
        if (!empty) begin
          tail_d  = bdq_pkg::ring_prev(tail_q);
          count_d = count_q - bdq_pkg::CntW'(1);
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::REQ_REPORT: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;  // unused codes report without success
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= bdq_pkg::CapReset;
      ok_q    <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
        ok_q    <= ok_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  bdq_ram #(
    .Width (bdq_pkg::DataW),
    .Depth (bdq_pkg::Depth)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.exec && we),
    .waddr_i   (waddr),
    .wdata_i   (push_value_i),
    .re_i      (cmd_i.read),
    .raddr_a_i (head_q),
    .raddr_b_i (bdq_pkg::ring_prev(tail_q)),
    .rdata_a_o (rdata_front),
    .rdata_b_o (rdata_rear)
  );

  // flags come from the registered state, which holds through the result cycle
  assign accepted_o    = ok_q;
  assign is_empty_o    = empty;
  assign is_full_o     = full;
  assign front_value_o = empty ? '1 : rdata_front;
  assign rear_value_o  = empty ? '1 : rdata_rear;

endmodule
